### hw/rtl/swp_pkg.sv
// Shared types and constants for the swap slot chain allocator.
package swp_pkg;

  localparam int unsigned HeadW   = 6;
  localparam int unsigned PageW   = 32;
  localparam int unsigned BaseW   = 20;
  localparam int unsigned BlockW  = 21;
  localparam int unsigned BlkShft = 3;

  localparam logic [PageW-1:0] FREE_MARK = '1;

  localparam logic KIND_STORE  = 1'b0;
  localparam logic KIND_FREE   = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              has_chain;
    logic [HeadW-1:0]  head_slot;
    logic [PageW-1:0]  page_addr;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [HeadW-1:0]  slot;
    logic [BlockW-1:0] first_block;
    logic [HeadW-1:0]  new_head;
    logic              head_valid;
  } rsp_t;

  typedef struct packed {
    logic page_we;
    logic link_we;
  } mem_we_t;

endpackage

### hw/rtl/swap_slot_chain_allocator.sv
// Top level of the swap slot chain allocator: config register, sequencer and slot table.
// After reset the block clears the slot table with busy high. A request first reduces
// head_slot by subtracting SLOTS until it is below SLOTS, then walks the chain (or frees
// each chain slot for a free request); a store whose page is not found in the chain
// then scans for a free entry and allocates it, writing the link from the last walked slot
// when needed. The slot table delivers one entry per cycle. The result word is shown for
// exactly one cycle with res_valid_o and must be taken then; busy falls in that same
// cycle. base_block may be written whenever the block is idle.
module swap_slot_chain_allocator #(
  parameter int unsigned SLOTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  swp_pkg::req_t  req_i,
  output swp_pkg::rsp_t  res_o,
  output logic           res_valid_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [19:0]    cfg_data_i
);
  import swp_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS+1);

  logic [BaseW-1:0] base_block_q;
  logic [AW-1:0]    rd_addr, wr_addr;
  mem_we_t          we;
  logic [PageW-1:0] page_wd, page_rd;
  logic [LW-1:0]    link_wd, link_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_block_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_block_q <= cfg_data_i;
    end
  end

  swp_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .base_block_i(base_block_q),
    .res_o       (res_o),
    .res_valid_o (res_valid_o),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .we_o        (we),
    .page_wd_o   (page_wd),
    .link_wd_o   (link_wd),
    .page_rd_i   (page_rd),
    .link_rd_i   (link_rd)
  );

  swp_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .we_i     (we),
    .page_wd_i(page_wd),
    .link_wd_i(link_wd),
    .page_rd_o(page_rd),
    .link_rd_o(link_rd)
  );

endmodule

### hw/rtl/swp_mem.sv
// Slot table memories: page word and next-slot link per slot, with write forwarding.
module swp_mem #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic [$clog2(SLOTS)-1:0]     rd_addr_i,
  input  logic [$clog2(SLOTS)-1:0]     wr_addr_i,
  input  swp_pkg::mem_we_t             we_i,
  input  logic [31:0]                  page_wd_i,
  input  logic [$clog2(SLOTS+1)-1:0]   link_wd_i,
  output logic [31:0]                  page_rd_o,
  output logic [$clog2(SLOTS+1)-1:0]   link_rd_o
);
  import swp_pkg::*;

  localparam int unsigned LW = $clog2(SLOTS+1);

  logic [PageW-1:0] page_mem [SLOTS];
  logic [LW-1:0]    link_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i.page_we) begin
      page_mem[wr_addr_i] <= page_wd_i;
    end
    if (we_i.link_we) begin
      link_mem[wr_addr_i] <= link_wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i.page_we && (wr_addr_i == rd_addr_i)) begin
      page_rd_o <= page_wd_i;
    end else begin
      page_rd_o <= page_mem[rd_addr_i];
    end
    if (we_i.link_we && (wr_addr_i == rd_addr_i)) begin
      link_rd_o <= link_wd_i;
    end else begin
      link_rd_o <= link_mem[rd_addr_i];
    end
  end

endmodule

### hw/rtl/swp_ctrl.sv
// Request sequencer: clearing pass, head reduction, chain walk or free, free scan, allocation and result word.
module swp_ctrl #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  swp_pkg::req_t                req_i,
  input  logic [19:0]                  base_block_i,
  output swp_pkg::rsp_t                res_o,
  output logic                         res_valid_o,
  output logic [$clog2(SLOTS)-1:0]     rd_addr_o,
  output logic [$clog2(SLOTS)-1:0]     wr_addr_o,
  output swp_pkg::mem_we_t             we_o,
  output logic [31:0]                  page_wd_o,
  output logic [$clog2(SLOTS+1)-1:0]   link_wd_o,
  input  logic [31:0]                  page_rd_i,
  input  logic [$clog2(SLOTS+1)-1:0]   link_rd_i
);
  import swp_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS+1);
  localparam int unsigned CW = $clog2(SLOTS+1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_REDUCE = 3'd2;
  localparam logic [2:0] ST_FREE   = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_ALLOC  = 3'd6;
  localparam logic [2:0] ST_LINK   = 3'd7;

  localparam logic [AW-1:0] LastIdx  = AW'(SLOTS - 1);
  localparam logic [CW-1:0] LastStep = CW'(SLOTS - 1);

  logic [2:0]       st_q, st_d;
  logic             kind_q, kind_d;
  logic             has_q, has_d;
  logic [HeadW-1:0] head_q, head_d;
  logic [PageW-1:0] page_q, page_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [CW-1:0]    steps_q, steps_d;
  logic [AW-1:0]    sc_q, sc_d;
  logic [AW-1:0]    ns_q, ns_d;
  rsp_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             more;
  logic [AW-1:0]    nx;

  function automatic logic [BlockW-1:0] block_of(logic [19:0] base, logic [AW-1:0] s);
    block_of = BlockW'(base) + BlockW'({s, {BlkShft{1'b0}}});
  endfunction

  assign more = (link_rd_i != '0) && (32'(link_rd_i) <= SLOTS);
  assign nx   = AW'(link_rd_i - LW'(1));

  always_comb begin
    st_d        = st_q;
    kind_d      = kind_q;
    has_d       = has_q;
    head_d      = head_q;
    page_d      = page_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    sc_d        = sc_q;
    ns_d        = ns_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    rd_addr_o   = cur_q;
    wr_addr_o   = cur_q;
    we_o        = '0;
    page_wd_o   = FREE_MARK;
    link_wd_o   = '0;

    case (st_q)
      ST_CLEAR: begin
        wr_addr_o    = sc_q;
        we_o.page_we = 1'b1;
        if (sc_q == LastIdx) begin
          sc_d = '0;
          st_d = ST_IDLE;
        end else begin
          sc_d = sc_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          kind_d = req_i.kind;
          has_d  = req_i.has_chain;
          head_d = req_i.head_slot;
          page_d = req_i.page_addr;
          st_d   = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        steps_d = '0;
        if (32'(head_q) >= SLOTS) begin
          head_d = head_q - HeadW'(SLOTS);
        end else if (kind_q == KIND_FREE) begin
          if (has_q) begin
            cur_d     = AW'(head_q);
            rd_addr_o = AW'(head_q);
            st_d      = ST_FREE;
          end else begin
            res_d       = '0;
            res_valid_d = 1'b1;
            st_d        = ST_IDLE;
          end
        end else if (has_q) begin
          cur_d     = AW'(head_q);
          rd_addr_o = AW'(head_q);
          st_d      = ST_WALK;
        end else begin
          sc_d      = '0;
          rd_addr_o = '0;
          st_d      = ST_SCAN;
        end
      end
      ST_FREE: begin
        wr_addr_o    = cur_q;
        we_o.page_we = 1'b1;
        we_o.link_we = 1'b1;
        if (!more || (steps_q == LastStep)) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end else begin
          cur_d     = nx;
          rd_addr_o = nx;
          steps_d   = steps_q + CW'(1);
        end
      end
      ST_WALK: begin
        if (page_rd_i == page_q) begin
          res_d.status      = STATUS_DONE;
          res_d.slot        = HeadW'(cur_q);
          res_d.first_block = block_of(base_block_i, cur_q);
          res_d.new_head    = head_q;
          res_d.head_valid  = 1'b1;
          res_valid_d       = 1'b1;
          st_d              = ST_IDLE;
        end else if (!more || (steps_q == LastStep)) begin
          sc_d      = '0;
          rd_addr_o = '0;
          st_d      = ST_SCAN;
        end else begin
          cur_d     = nx;
          rd_addr_o = nx;
          steps_d   = steps_q + CW'(1);
        end
      end
      ST_SCAN: begin
        rd_addr_o = sc_q + AW'(1);
        if (page_rd_i == FREE_MARK) begin
          ns_d = sc_q;
          st_d = ST_ALLOC;
        end else if (sc_q == LastIdx) begin
          res_d.status      = STATUS_FULL;
          res_d.slot        = '0;
          res_d.first_block = '0;
          res_d.new_head    = has_q ? head_q : '0;
          res_d.head_valid  = has_q;
          res_valid_d       = 1'b1;
          st_d              = ST_IDLE;
        end else begin
          sc_d = sc_q + AW'(1);
        end
      end
      ST_ALLOC: begin
        wr_addr_o         = ns_q;
        we_o.page_we      = 1'b1;
        we_o.link_we      = 1'b1;
        page_wd_o         = page_q;
        res_d.status      = STATUS_DONE;
        res_d.slot        = HeadW'(ns_q);
        res_d.first_block = block_of(base_block_i, ns_q);
        res_d.new_head    = has_q ? head_q : HeadW'(ns_q);
        res_d.head_valid  = 1'b1;
        if (has_q && (cur_q != ns_q)) begin
          st_d = ST_LINK;
        end else begin
          res_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      ST_LINK: begin
        wr_addr_o    = cur_q;
        we_o.link_we = 1'b1;
        link_wd_o    = LW'(ns_q) + LW'(1);
        res_valid_d  = 1'b1;
        st_d         = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      sc_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      sc_q        <= sc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    has_q   <= has_d;
    head_q  <= head_d;
    page_q  <= page_d;
    cur_q   <= cur_d;
    steps_q <= steps_d;
    ns_q    <= ns_d;
    res_q   <= res_d;
  end

  assign busy        = (st_q != ST_IDLE);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> busy)
    else $error("clearing pass not flagged busy");

  a_accept_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (st_q == ST_REDUCE))
    else $error("accepted request did not enter head reduction");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe longer than one cycle");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == STATUS_FULL)) |->
      ((res_q.slot == '0) && (res_q.first_block == '0)))
    else $error("full-table result carries a slot");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_WALK) || (st_q == ST_FREE)) |-> (steps_q <= LastStep))
    else $error("chain walk exceeded table size");

endmodule
